// ----- hw/rtl/rarmt_pkg.sv -----
// Shared types and constants for the range-add / range-max lazy segment tree.
// Used by every file of the block; depends on nothing.
package rarmt_pkg;

  localparam int unsigned IDX_W = 11;
  localparam int unsigned ADD_W = 48;
  localparam int unsigned VAL_W = 64;

  localparam logic [VAL_W-1:0] NEG_INF = 64'hF000_0000_0000_0001;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_SEL,
    ST_PUSH_CHK,
    ST_PUSH_L,
    ST_PUSH_R,
    ST_TAG_B,
    ST_TAG_BW,
    ST_TAG_A,
    ST_TAG_AW,
    ST_TAG_SH,
    ST_FIX_SEL,
    ST_FIX_L,
    ST_FIX_R,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic max_we;
    logic pend_we;
  } wr_en_t;

endpackage

// ----- hw/rtl/range_add_range_max_tree.sv -----
// Top level of the range-add / range-max lazy segment tree.
// Depends on rarmt_pkg, rarmt_node_mem and rarmt_seq.
//
//  channel | dir | handshake                | payload
//  cfg     | in  | cfg_valid / cfg_ready    | cfg_data = leaves_in_use
//  in      | in  | in_tvalid / in_tready    | tuser = opcode, tdata = start, end, add value
//  out     | out | out_tvalid / out_tready  | tdata = range maximum (queries only)
//
// After reset a clearing pass zeroes all 2^(TREE_LEVELS+1) entries of the node store;
// in_tready stays low meanwhile, cfg writes are taken.
// One item runs a push-down along both path edges, handing each pending add on an inner
// path node to its two children, then the range walk, and for adds a fix-up that
// recomputes the inner nodes on both path edges; the steps run one after another
// over the single read and single write port of the node store.
// A query result sits in an output register; the next item is taken while it waits.
module range_add_range_max_tree #(
  parameter int unsigned TREE_LEVELS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,    // leaves_in_use
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,    // range_start[10:0], range_end[21:11], add_value[69:22]
  input  logic [0:0]  in_tuser,    // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata    // range_maximum
);

  localparam int unsigned KW = TREE_LEVELS + 1;
  localparam int unsigned CAP = 1 << TREE_LEVELS;

  function automatic logic [KW-1:0] width_of(input logic [10:0] v);
    logic [31:0] want;
    logic [KW-1:0] w;
    logic found;
    want  = (v == '0) ? 32'd1 : ((32'(v) > 32'(CAP)) ? 32'(CAP) : 32'(v));
    w     = '0;
    found = 1'b0;
    for (int i = 0; i <= TREE_LEVELS; i++) begin
      if (!found && ((32'd1 << i) >= want)) begin
        w     = KW'(1) << i;
        found = 1'b1;
      end
    end
    return w;
  endfunction

  logic [KW-1:0] n0_r;
  logic          out_valid_r;
  logic [63:0]   out_data_r;

  logic                        res_valid, res_ready;
  logic [rarmt_pkg::VAL_W-1:0] res_data;
  logic [KW-1:0]               rd_addr, wr_addr;
  logic [rarmt_pkg::VAL_W-1:0] rd_max, rd_pend, wd_max, wd_pend;
  rarmt_pkg::wr_en_t           wr_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_r <= width_of(11'd1024);
    end else if (cfg_valid) begin
      n0_r <= width_of(cfg_data);
    end
  end

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  rarmt_seq #(
    .TREE_LEVELS(TREE_LEVELS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .n0       (n0_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser[0]),
    .in_start (in_tdata[10:0]),
    .in_end   (in_tdata[21:11]),
    .in_value (in_tdata[69:22]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .rd_addr  (rd_addr),
    .rd_max   (rd_max),
    .rd_pend  (rd_pend),
    .wr_addr  (wr_addr),
    .wr_en    (wr_en),
    .wd_max   (wd_max),
    .wd_pend  (wd_pend)
  );

  rarmt_node_mem #(
    .TREE_LEVELS(TREE_LEVELS)
  ) u_mem (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_max (rd_max),
    .rd_pend(rd_pend),
    .wr_addr(wr_addr),
    .wr_en  (wr_en),
    .wd_max (wd_max),
    .wd_pend(wd_pend)
  );

endmodule

// ----- hw/rtl/rarmt_node_mem.sv -----
// Node store: per-node maximum and pending add, one read and one write port.
// Depends on rarmt_pkg.
module rarmt_node_mem #(
  parameter int unsigned TREE_LEVELS = 10
) (
  input  logic                        clk,
  input  logic [TREE_LEVELS:0]        rd_addr,
  output logic [rarmt_pkg::VAL_W-1:0] rd_max,
  output logic [rarmt_pkg::VAL_W-1:0] rd_pend,
  input  logic [TREE_LEVELS:0]        wr_addr,
  input  rarmt_pkg::wr_en_t           wr_en,
  input  logic [rarmt_pkg::VAL_W-1:0] wd_max,
  input  logic [rarmt_pkg::VAL_W-1:0] wd_pend
);

  localparam int unsigned DEPTH = 2 << TREE_LEVELS;

  logic [rarmt_pkg::VAL_W-1:0] max_mem  [DEPTH];
  logic [rarmt_pkg::VAL_W-1:0] pend_mem [DEPTH];
  logic [rarmt_pkg::VAL_W-1:0] rd_max_r;
  logic [rarmt_pkg::VAL_W-1:0] rd_pend_r;

  always_ff @(posedge clk) begin
    if (wr_en.max_we) begin
      max_mem[wr_addr] <= wd_max;
    end
    if (wr_en.pend_we) begin
      pend_mem[wr_addr] <= wd_pend;
    end
    rd_max_r  <= max_mem[rd_addr];
    rd_pend_r <= pend_mem[rd_addr];
  end

  assign rd_max  = rd_max_r;
  assign rd_pend = rd_pend_r;

endmodule

// ----- hw/rtl/rarmt_seq.sv -----
// Sequencer: push-down, tagging / query walk and ancestor fix-up over the node store.
// Depends on rarmt_pkg.
module rarmt_seq #(
  parameter int unsigned TREE_LEVELS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [TREE_LEVELS:0]        n0,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [rarmt_pkg::IDX_W-1:0] in_start,
  input  logic [rarmt_pkg::IDX_W-1:0] in_end,
  input  logic [rarmt_pkg::ADD_W-1:0] in_value,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [rarmt_pkg::VAL_W-1:0] res_data,
  output logic [TREE_LEVELS:0]        rd_addr,
  input  logic [rarmt_pkg::VAL_W-1:0] rd_max,
  input  logic [rarmt_pkg::VAL_W-1:0] rd_pend,
  output logic [TREE_LEVELS:0]        wr_addr,
  output rarmt_pkg::wr_en_t           wr_en,
  output logic [rarmt_pkg::VAL_W-1:0] wd_max,
  output logic [rarmt_pkg::VAL_W-1:0] wd_pend
);

  localparam int unsigned KW  = TREE_LEVELS + 1;
  localparam int unsigned AW  = TREE_LEVELS + 2;
  localparam int unsigned LVW = $clog2(TREE_LEVELS + 2);
  localparam logic [LVW-1:0] LVL_TOP = LVW'(TREE_LEVELS + 1);
  localparam logic [LVW-1:0] LVL_BOT = LVW'(1);

  rarmt_pkg::state_t state_r, state_nxt;

  logic [KW-1:0]  clr_r, clr_nxt;
  logic [LVW-1:0] lvl_r, lvl_nxt;
  logic           side_r, side_nxt;
  logic           op_r, op_nxt;
  logic [AW-1:0]  ea_r, ea_nxt, eb_r, eb_nxt;
  logic [AW-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [KW-1:0]  kn_r, kn_nxt;
  logic [rarmt_pkg::VAL_W-1:0] val_r, val_nxt, tag_r, tag_nxt;
  logic [rarmt_pkg::VAL_W-1:0] left_r, left_nxt, best_r, best_nxt;

  logic [AW-1:0] at, bt, lmask, kfull, bm1;
  logic          first, inc_a, inc_b, usable;
  logic          push_last, fix_last;
  logic [LVW-1:0] push_lvl, fix_lvl;
  logic           push_side, fix_side;
  logic [31:0]    lo32, hi32, n032, lo_c, hi_c;

  always_comb begin
    at    = ea_r >> lvl_r;
    bt    = eb_r >> lvl_r;
    lmask = (AW'(1) << lvl_r) - AW'(1);
    first = at < bt;
    inc_a = (at != '0) && (first ? ((ea_r & lmask) != '0) : 1'b1);
    inc_b = (at != '0) && first && ((eb_r & lmask) != '0);
    kfull = side_r ? bt : at;
    usable = (side_r ? inc_b : inc_a) && (kfull != '0) && (kfull < {1'b0, n0});
    bm1 = b_r - AW'(1);

    push_last = (lvl_r == LVL_BOT) && side_r;
    push_side = ~side_r;
    push_lvl  = side_r ? lvl_r - LVW'(1) : lvl_r;
    fix_last  = (lvl_r == LVL_TOP) && !side_r;
    fix_side  = ~side_r;
    fix_lvl   = side_r ? lvl_r : lvl_r + LVW'(1);

    lo32 = {{(32 - rarmt_pkg::IDX_W){1'b0}}, in_start};
    hi32 = {{(32 - rarmt_pkg::IDX_W){1'b0}}, in_end};
    n032 = {{(32 - KW){1'b0}}, n0};
    lo_c = (lo32 > n032) ? n032 : lo32;
    hi_c = (hi32 > n032) ? n032 : hi32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rarmt_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    lvl_r  <= lvl_nxt;
    side_r <= side_nxt;
    op_r   <= op_nxt;
    ea_r   <= ea_nxt;
    eb_r   <= eb_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    kn_r   <= kn_nxt;
    val_r  <= val_nxt;
    tag_r  <= tag_nxt;
    left_r <= left_nxt;
    best_r <= best_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    lvl_nxt   = lvl_r;
    side_nxt  = side_r;
    op_nxt    = op_r;
    ea_nxt    = ea_r;
    eb_nxt    = eb_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    kn_nxt    = kn_r;
    val_nxt   = val_r;
    tag_nxt   = tag_r;
    left_nxt  = left_r;
    best_nxt  = best_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    rd_addr   = kn_r;
    wr_addr   = kn_r;
    wr_en     = '0;
    wd_max    = rd_max + tag_r;
    wd_pend   = rd_pend + tag_r;

    unique case (state_r)
      rarmt_pkg::ST_CLEAR: begin
        wr_addr = clr_r;
        wr_en   = '{max_we: 1'b1, pend_we: 1'b1};
        wd_max  = '0;
        wd_pend = '0;
        clr_nxt = clr_r + KW'(1);
        if (clr_r == '1) begin
          state_nxt = rarmt_pkg::ST_IDLE;
        end
      end
      rarmt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt   = in_op;
          ea_nxt   = AW'(lo_c + n032);
          eb_nxt   = AW'(hi_c + n032);
          a_nxt    = AW'(lo_c + n032);
          b_nxt    = AW'(hi_c + n032);
          val_nxt  = {{(rarmt_pkg::VAL_W - rarmt_pkg::ADD_W){in_value[rarmt_pkg::ADD_W-1]}},
                      in_value};
          best_nxt = rarmt_pkg::NEG_INF;
          lvl_nxt  = LVL_TOP;
          side_nxt = 1'b0;
          state_nxt = rarmt_pkg::ST_PUSH_SEL;
        end
      end
      rarmt_pkg::ST_PUSH_SEL: begin
        if (usable) begin
          rd_addr   = kfull[KW-1:0];
          kn_nxt    = kfull[KW-1:0];
          state_nxt = rarmt_pkg::ST_PUSH_CHK;
        end else begin
          lvl_nxt  = push_lvl;
          side_nxt = push_side;
          state_nxt = push_last ? rarmt_pkg::ST_TAG_B : rarmt_pkg::ST_PUSH_SEL;
        end
      end
      rarmt_pkg::ST_PUSH_CHK: begin
        if (rd_pend == '0) begin
          lvl_nxt  = push_lvl;
          side_nxt = push_side;
          state_nxt = push_last ? rarmt_pkg::ST_TAG_B : rarmt_pkg::ST_PUSH_SEL;
        end else begin
          tag_nxt   = rd_pend;
          wr_en     = '{max_we: 1'b0, pend_we: 1'b1};
          wd_pend   = '0;
          rd_addr   = {kn_r[KW-2:0], 1'b0};
          state_nxt = rarmt_pkg::ST_PUSH_L;
        end
      end
      rarmt_pkg::ST_PUSH_L: begin
        wr_addr   = {kn_r[KW-2:0], 1'b0};
        wr_en     = '{max_we: 1'b1, pend_we: 1'b1};
        rd_addr   = {kn_r[KW-2:0], 1'b1};
        state_nxt = rarmt_pkg::ST_PUSH_R;
      end
      rarmt_pkg::ST_PUSH_R: begin
        wr_addr  = {kn_r[KW-2:0], 1'b1};
        wr_en    = '{max_we: 1'b1, pend_we: 1'b1};
        lvl_nxt  = push_lvl;
        side_nxt = push_side;
        state_nxt = push_last ? rarmt_pkg::ST_TAG_B : rarmt_pkg::ST_PUSH_SEL;
      end
      rarmt_pkg::ST_TAG_B: begin
        if (!(a_r < b_r)) begin
          if (op_r == rarmt_pkg::OP_ADD) begin
            lvl_nxt   = LVL_BOT;
            side_nxt  = 1'b1;
            state_nxt = rarmt_pkg::ST_FIX_SEL;
          end else begin
            state_nxt = rarmt_pkg::ST_DONE;
          end
        end else if (b_r[0]) begin
          b_nxt   = bm1;
          rd_addr = bm1[KW-1:0];
          state_nxt = (bm1 != '0) ? rarmt_pkg::ST_TAG_BW : rarmt_pkg::ST_TAG_A;
        end else begin
          state_nxt = rarmt_pkg::ST_TAG_A;
        end
      end
      rarmt_pkg::ST_TAG_BW: begin
        wr_addr = b_r[KW-1:0];
        wd_max  = rd_max + val_r;
        wd_pend = rd_pend + val_r;
        if (op_r == rarmt_pkg::OP_ADD) begin
          wr_en = '{max_we: 1'b1, pend_we: 1'b1};
        end else if ($signed(rd_max) > $signed(best_r)) begin
          best_nxt = rd_max;
        end
        state_nxt = rarmt_pkg::ST_TAG_A;
      end
      rarmt_pkg::ST_TAG_A: begin
        rd_addr = a_r[KW-1:0];
        state_nxt = a_r[0] ? rarmt_pkg::ST_TAG_AW : rarmt_pkg::ST_TAG_SH;
      end
      rarmt_pkg::ST_TAG_AW: begin
        wr_addr = a_r[KW-1:0];
        wd_max  = rd_max + val_r;
        wd_pend = rd_pend + val_r;
        if (op_r == rarmt_pkg::OP_ADD) begin
          wr_en = '{max_we: 1'b1, pend_we: 1'b1};
        end else if ($signed(rd_max) > $signed(best_r)) begin
          best_nxt = rd_max;
        end
        a_nxt = a_r + AW'(1);
        state_nxt = rarmt_pkg::ST_TAG_SH;
      end
      rarmt_pkg::ST_TAG_SH: begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        state_nxt = rarmt_pkg::ST_TAG_B;
      end
      rarmt_pkg::ST_FIX_SEL: begin
        if (usable) begin
          kn_nxt    = kfull[KW-1:0];
          rd_addr   = {kfull[KW-2:0], 1'b0};
          state_nxt = rarmt_pkg::ST_FIX_L;
        end else begin
          lvl_nxt  = fix_lvl;
          side_nxt = fix_side;
          state_nxt = fix_last ? rarmt_pkg::ST_IDLE : rarmt_pkg::ST_FIX_SEL;
        end
      end
      rarmt_pkg::ST_FIX_L: begin
        left_nxt  = rd_max;
        rd_addr   = {kn_r[KW-2:0], 1'b1};
        state_nxt = rarmt_pkg::ST_FIX_R;
      end
      rarmt_pkg::ST_FIX_R: begin
        wr_en    = '{max_we: 1'b1, pend_we: 1'b0};
        wd_max   = ($signed(left_r) > $signed(rd_max)) ? left_r : rd_max;
        lvl_nxt  = fix_lvl;
        side_nxt = fix_side;
        state_nxt = fix_last ? rarmt_pkg::ST_IDLE : rarmt_pkg::ST_FIX_SEL;
      end
      rarmt_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = rarmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rarmt_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_data = best_r;

endmodule

// ----- tb/range_add_range_max_tree_check.sv -----
`timescale 1ns / 1ps
// Checker for range_add_range_max_tree: watches the cfg, in and out channels,
// keeps its own lazy segment tree and compares each range maximum. Uses rarmt_pkg.
module range_add_range_max_tree_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  output int          errors,
  output int          maxima_pending
);

  localparam int unsigned NODES = 2048;

  logic [10:0]                 leaves;
  logic [rarmt_pkg::VAL_W-1:0] tree_max [0:NODES-1];
  logic [rarmt_pkg::VAL_W-1:0] tree_tag [0:NODES-1];
  int unsigned                 walk [0:23];
  int unsigned                 walk_len;
  logic [rarmt_pkg::VAL_W-1:0] max_queue [$];

  assign maxima_pending = max_queue.size();

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [rarmt_pkg::VAL_W-1:0] larger(
    input logic [rarmt_pkg::VAL_W-1:0] x,
    input logic [rarmt_pkg::VAL_W-1:0] y);
    return ($signed(x) > $signed(y)) ? x : y;
  endfunction

  function automatic int unsigned span_width();
    int unsigned want;
    int unsigned w;
    want = (leaves > 11'd1024) ? 1024 : leaves;
    w = 1;
    while (w < want) w <<= 1;
    return w;
  endfunction

  function automatic void walk_push(input int unsigned k);
    if (walk_len < 24) begin
      walk[walk_len] = k;
      walk_len++;
    end
  endfunction

  function automatic void collect_walk(input int unsigned lo, input int unsigned hi,
                                       input int unsigned n0);
    int unsigned a, b, la, lb;
    a = lo + n0;
    b = hi + n0;
    la = (a & (~a + 1)) >> 1;
    lb = (b & (~b + 1)) >> 1;
    a >>= 1;
    b >>= 1;
    walk_len = 0;
    while (a > 0 && a < b) begin
      if (lb == 0) walk_push(b);
      if (la == 0) walk_push(a);
      la >>= 1;
      lb >>= 1;
      a >>= 1;
      b >>= 1;
    end
    while (a > 0) begin
      walk_push(a);
      a >>= 1;
    end
  endfunction

  function automatic void tag_node(input int unsigned k,
                                   input logic [rarmt_pkg::VAL_W-1:0] v);
    if (k >= 1 && k < NODES) begin
      tree_tag[k] = tree_tag[k] + v;
      tree_max[k] = tree_max[k] + v;
    end
  endfunction

  // returns 1 and the maximum for a query, 0 for an add
  function automatic bit apply_request(input logic op, input logic [10:0] lo_in,
                                       input logic [10:0] hi_in,
                                       input logic [rarmt_pkg::ADD_W-1:0] amount,
                                       output logic [rarmt_pkg::VAL_W-1:0] best);
    int unsigned n0, lo, hi, a, b, k;
    logic [rarmt_pkg::VAL_W-1:0] v;
    n0 = span_width();
    lo = (lo_in > n0) ? n0 : lo_in;
    hi = (hi_in > n0) ? n0 : hi_in;
    collect_walk(lo, hi, n0);
    for (int i = int'(walk_len) - 1; i >= 0; i--) begin
      k = walk[i];
      if (k != 0 && k < n0 && tree_tag[k] != 0) begin
        tag_node(2 * k, tree_tag[k]);
        tag_node(2 * k + 1, tree_tag[k]);
        tree_tag[k] = '0;
      end
    end
    a = lo + n0;
    b = hi + n0;
    best = rarmt_pkg::NEG_INF;
    if (op == rarmt_pkg::OP_ADD) begin
      v = {{(rarmt_pkg::VAL_W-rarmt_pkg::ADD_W){amount[rarmt_pkg::ADD_W-1]}}, amount};
      while (a < b) begin
        if (b & 1) begin
          b--;
          tag_node(b, v);
        end
        if (a & 1) begin
          tag_node(a, v);
          a++;
        end
        a >>= 1;
        b >>= 1;
      end
      for (int i = 0; i < walk_len; i++) begin
        k = walk[i];
        if (k != 0 && k < n0) tree_max[k] = larger(tree_max[2 * k], tree_max[2 * k + 1]);
      end
      return 0;
    end
    while (a < b) begin
      if (b & 1) begin
        b--;
        if (b >= 1 && b < NODES) best = larger(best, tree_max[b]);
      end
      if (a & 1) begin
        if (a >= 1 && a < NODES) best = larger(best, tree_max[a]);
        a++;
      end
      a >>= 1;
      b >>= 1;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    logic [rarmt_pkg::VAL_W-1:0] got_max;
    logic [rarmt_pkg::VAL_W-1:0] want_max;
    if (!rst_n) begin
      leaves = 11'd1024;
      for (int i = 0; i < NODES; i++) begin
        tree_max[i] = '0;
        tree_tag[i] = '0;
      end
      max_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) leaves = cfg_data;
      if (in_tvalid && in_tready) begin
        if (apply_request(in_tuser[0], in_tdata[10:0], in_tdata[21:11], in_tdata[69:22],
                          got_max))
          max_queue.push_back(got_max);
      end
      if (out_tvalid && out_tready) begin
        if (max_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected range maximum %h", out_tdata));
        end else begin
          want_max = max_queue.pop_front();
          if (out_tdata !== want_max)
            report_mismatch($sformatf("range maximum %h, want %h", out_tdata, want_max));
        end
      end
    end
  end

endmodule

// ----- tb/range_add_range_max_tree_test.sv -----
`timescale 1ns / 1ps
// Testbench top for range_add_range_max_tree: drives add and query items and
// tree lengths, stalls the result side; checking in range_add_range_max_tree_check.
module range_add_range_max_tree_test;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  int          errors;
  int          maxima_pending;
  int          quiet_cycles = 0;
  logic [10:0] cur_leaves = 11'd1024;

  always #6 clk = ~clk;

  range_add_range_max_tree i_dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  range_add_range_max_tree_check i_check (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .errors, .maxima_pending
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("range_add_range_max_tree_test failed");
      $finish;
    end
  end

  // result side: random stalls, runs without stalls, two long hold-offs
  initial begin
    int taken;
    int stall;
    bit busy_mode;
    taken = 0;
    busy_mode = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(31) == 0) busy_mode = ~busy_mode;
      stall = busy_mode ? 0 : $urandom_range(17);
      if (taken == 10 || taken == 300) stall = 500;
      repeat (stall) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  task automatic send_item(input logic op, input logic [10:0] lo, input logic [10:0] hi,
                           input logic [rarmt_pkg::ADD_W-1:0] amount);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {2'b00, amount, hi, lo};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic set_leaves(input logic [10:0] n);
    in_tvalid <= 1'b0;
    wait (maxima_pending == 0);
    repeat (SETTLE) @(negedge clk);
    cfg_data  <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_leaves = n;
  endtask

  function automatic logic [rarmt_pkg::ADD_W-1:0] pick_amount();
    case ($urandom_range(5))
      0:       return 48'h8000_0000_0000;
      1:       return 48'h7FFF_FFFF_FFFF;
      2:       return 48'({$urandom, $urandom});
      3:       return 48'(int'($urandom_range(200)) - 100);
      default: return {{16{1'b0}}, $urandom} - 48'h8000_0000;
    endcase
  endfunction

  task automatic random_item();
    int n0;
    int lo;
    int hi;
    n0 = 1;
    while (n0 < ((cur_leaves > 1024) ? 1024 : cur_leaves)) n0 <<= 1;
    case ($urandom_range(9))
      0: begin
        lo = $urandom_range(1024);
        hi = $urandom_range(1024);
      end
      1: begin
        lo = $urandom_range(n0);
        hi = lo;
      end
      default: begin
        lo = $urandom_range(n0 - 1);
        hi = $urandom_range(n0, lo + 1);
      end
    endcase
    send_item(logic'($urandom_range(1)), 11'(lo), 11'(hi), pick_amount());
  endtask

  initial begin
    logic [10:0] lengths [0:7];
    lengths = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd5, 11'd300, 11'd1024, 11'd37};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_leaves(11'd1024);
    send_item(rarmt_pkg::OP_ADD,   11'd0,    11'd1024, 48'h7FFF_FFFF_FFFF);
    send_item(rarmt_pkg::OP_QUERY, 11'd0,    11'd1024, 48'h0);
    send_item(rarmt_pkg::OP_QUERY, 11'd5,    11'd5,    48'h0);
    send_item(rarmt_pkg::OP_QUERY, 11'd10,   11'd3,    48'hFFFF_FFFF_FFFF);
    send_item(rarmt_pkg::OP_ADD,   11'd0,    11'd1,    48'h8000_0000_0000);
    send_item(rarmt_pkg::OP_QUERY, 11'd0,    11'd1,    48'h0);
    send_item(rarmt_pkg::OP_ADD,   11'd1023, 11'd1024, 48'h8000_0000_0000);
    send_item(rarmt_pkg::OP_QUERY, 11'd1023, 11'd1024, 48'h0);
    send_item(rarmt_pkg::OP_QUERY, 11'd1024, 11'd1024, 48'h0);
    send_item(rarmt_pkg::OP_ADD,   11'd7,    11'd7,    48'h1234_5678_9ABC);
    send_item(rarmt_pkg::OP_ADD,   11'd3,    11'd700,  48'h0);
    send_item(rarmt_pkg::OP_ADD,   11'd3,    11'd700,  48'h0000_0000_0001);
    send_item(rarmt_pkg::OP_QUERY, 11'd2,    11'd4,    48'h0);
    send_item(rarmt_pkg::OP_QUERY, 11'd699,  11'd701,  48'h0);
    send_item(rarmt_pkg::OP_ADD,   11'd1,    11'd1023, 48'hFFFF_FFFF_FFFF);
    send_item(rarmt_pkg::OP_QUERY, 11'd0,    11'd1024, 48'h0);
    send_item(rarmt_pkg::OP_QUERY, 11'd512,  11'd513,  48'h0);
    send_item(rarmt_pkg::OP_ADD,   11'd511,  11'd513,  48'h5555_5555_5555);
    send_item(rarmt_pkg::OP_QUERY, 11'd0,    11'd512,  48'h0);
    send_item(rarmt_pkg::OP_QUERY, 11'd1,    11'd1023, 48'h0);
    foreach (lengths[p]) begin
      set_leaves(lengths[p]);
      if (lengths[p] <= 11'd1) begin
        send_item(rarmt_pkg::OP_QUERY, 11'd0, 11'd1024, 48'h0);
        send_item(rarmt_pkg::OP_ADD,   11'd1, 11'd1024, 48'h0000_0000_0100);
        send_item(rarmt_pkg::OP_QUERY, 11'd0, 11'd2,    48'h0);
      end
      repeat (110) random_item();
    end
    in_tvalid <= 1'b0;
    wait (maxima_pending == 0);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0)
      $display("range_add_range_max_tree_test passed");
    else
      $display("range_add_range_max_tree_test failed");
    $finish;
  end

endmodule
